### hdl/key_table_linear_binary_search_assert.svh
// ----------------------------------------------------------------------------
// key table assertion macros
// concurrent checks that compile away when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef KEY_TABLE_LINEAR_BINARY_SEARCH_ASSERT_SVH
`define KEY_TABLE_LINEAR_BINARY_SEARCH_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define KT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key table assertion failed");

// next-cycle implication
`define KT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key table assertion failed");

`else

`define KT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define KT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hdl/ktlbs_pkg.sv
// ----------------------------------------------------------------------------
// key table package
// request and response types, command and status codes, control structs
// ----------------------------------------------------------------------------
`default_nettype none

package ktlbs_pkg;

   localparam int KEY_W = 32;
   localparam int POS_W = 10;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_LINEAR = 2'd2,
      CMD_BINARY = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      RS_OK        = 2'd0,
      RS_NOT_FOUND = 2'd1,
      RS_FULL      = 2'd2
   } resp_status_type;

   typedef struct packed {
      cmd_type                  command;
      logic signed [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      resp_status_type          status;
      logic [POS_W-1:0]         position;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_LIN,
      S_BIN_RD,
      S_BIN_CMP,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic             load_req;
      logic             clr_count;
      logic             wr_en;
      logic             lin_init;
      logic             bin_init;
      logic             rd_en;
      logic             rd_bin;
      logic             bin_step;
      logic             res_set;
      resp_status_type  res_status;
      logic             res_found;
      logic             rsp_load;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      cmd_type  command;
      logic     full;
      logic     lin_more;
      logic     bin_more;
      logic     rd_vld;
      logic     match;
      logic     slot_free;
   } stat_type;

endpackage

`default_nettype wire

### hdl/ktlbs_dp.sv
// ----------------------------------------------------------------------------
// key table datapath
// key memory, entry count, search pointers, pending result and response reg
// ----------------------------------------------------------------------------
`default_nettype none

module ktlbs_dp #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ktlbs_pkg::req_type  req_data,
   input  wire ktlbs_pkg::ctrl_type cmd,
   output ktlbs_pkg::stat_type      sts,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output ktlbs_pkg::rsp_type       rsp_data
);
   import ktlbs_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic signed [KEY_W-1:0] mem [TABLE_DEPTH];

   req_type                 req_ff;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           lo_ff, lo_in;
   logic [CW-1:0]           hi_ff, hi_in;
   logic signed [KEY_W-1:0] rd_data_ff;
   logic [AW-1:0]           rd_addr_ff;
   logic                    rd_vld_ff;
   resp_status_type         res_status_ff;
   logic [POS_W-1:0]        res_pos_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic [CW:0]             mid_sum;
   logic [AW-1:0]           mid;
   logic [AW-1:0]           rd_addr;
   logic [AW+POS_W-1:0]     pos_wide;
   logic                    less;

   // midpoint of [lo, hi-1]; only used while lo < hi
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff} - (CW+1)'(1);
   assign mid      = AW'(mid_sum >> 1);
   assign rd_addr  = cmd.rd_bin ? mid : idx_ff[AW-1:0];
   assign less     = rd_data_ff < req_ff.key;
   assign pos_wide = {{POS_W{1'b0}}, rd_addr_ff};

   always_comb begin
      count_in = count_ff;
      if (cmd.clr_count) begin
         count_in = '0;
      end else if (cmd.wr_en) begin
         count_in = count_ff + CW'(1);
      end

      idx_in = idx_ff;
      if (cmd.lin_init) begin
         idx_in = '0;
      end else if (cmd.rd_en && !cmd.rd_bin) begin
         idx_in = idx_ff + CW'(1);
      end

      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.bin_init) begin
         lo_in = '0;
         hi_in = count_ff;
      end else if (cmd.bin_step) begin
         if (less) begin
            lo_in = CW'(rd_addr_ff) + CW'(1);
         end else begin
            hi_in = CW'(rd_addr_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[count_ff[AW-1:0]] <= req_ff.key;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_vld_ff <= cmd.rd_en;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_pos_ff    <= cmd.res_found ? pos_wide[POS_W-1:0] : '0;
      end
      if (cmd.rsp_load) begin
         rsp_ff.status   <= res_status_ff;
         rsp_ff.position <= res_pos_ff;
      end
   end

   always_comb begin
      sts.command   = req_ff.command;
      sts.full      = (count_ff == CW'(TABLE_DEPTH));
      sts.lin_more  = (idx_ff < count_ff);
      sts.bin_more  = (lo_ff < hi_ff);
      sts.rd_vld    = rd_vld_ff;
      sts.match     = (rd_data_ff == req_ff.key);
      sts.slot_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### hdl/ktlbs_ctrl.sv
// ----------------------------------------------------------------------------
// key table controller
// sequences clear, append and the two searches over the datapath
// ----------------------------------------------------------------------------
`default_nettype none

module ktlbs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire ktlbs_pkg::stat_type sts,
   output ktlbs_pkg::ctrl_type      cmd,
   output ktlbs_pkg::state_type     state
);
   import ktlbs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.command)
               CMD_CLEAR: begin
                  cmd.clr_count  = 1'b1;
                  cmd.res_set    = 1'b1;
                  cmd.res_status = RS_OK;
                  state_in       = S_RESP;
               end
               CMD_APPEND: begin
                  cmd.wr_en      = !sts.full;
                  cmd.res_set    = 1'b1;
                  cmd.res_status = sts.full ? RS_FULL : RS_OK;
                  state_in       = S_RESP;
               end
               CMD_LINEAR: begin
                  cmd.lin_init = 1'b1;
                  state_in     = S_LIN;
               end
               CMD_BINARY: begin
                  cmd.bin_init = 1'b1;
                  state_in     = S_BIN_RD;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_LIN: begin
            // one read issued per cycle, each compared in the cycle after it is issued
            cmd.rd_en = sts.lin_more;
            if (sts.rd_vld && sts.match) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = RS_OK;
               cmd.res_found  = 1'b1;
               state_in       = S_RESP;
            end else if (!sts.rd_vld && !sts.lin_more) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = RS_NOT_FOUND;
               state_in       = S_RESP;
            end
         end
         S_BIN_RD: begin
            if (sts.bin_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_bin = 1'b1;
               state_in   = S_BIN_CMP;
            end else begin
               cmd.res_set    = 1'b1;
               cmd.res_status = RS_NOT_FOUND;
               state_in       = S_RESP;
            end
         end
         S_BIN_CMP: begin
            if (sts.match) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = RS_OK;
               cmd.res_found  = 1'b1;
               state_in       = S_RESP;
            end else begin
               cmd.bin_step = 1'b1;
               state_in     = S_BIN_RD;
            end
         end
         S_RESP: begin
            if (sts.slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign state     = state_ff;

endmodule

`default_nettype wire

### hdl/key_table_linear_binary_search.sv
// ----------------------------------------------------------------------------
// key table with linear and binary search
// clear and append: accept, decode, then load the response register; no new request until then
// linear search: one memory read per cycle over the table
// binary search: one read and compare per halving
// reset empties the table at once (count only, no clearing pass over the memory)
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_table_linear_binary_search_assert.svh"

module key_table_linear_binary_search #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire ktlbs_pkg::req_type req_data,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output ktlbs_pkg::rsp_type      rsp_data
);
   import ktlbs_pkg::*;

   // command and status between controller and datapath
   ctrl_type  cmd;
   stat_type  sts;
   state_type state;

   // controller: one request at a time, held in the datapath until answered
   ktlbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd),
      .state     (state)
   );

   // datapath: key memory with registered read port, count, search pointers,
   // and the response register that decouples the response side
   ktlbs_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a new response only goes into a free or draining response slot
   `KT_ASSERT_IMPLY(a_rsp_load_free, clock, reset, cmd.rsp_load, sts.slot_free)

   // a full table is never written
   `KT_ASSERT_IMPLY(a_no_write_full, clock, reset, cmd.wr_en, !sts.full)

   // memory reads come only from the search states
   `KT_ASSERT_IMPLY(a_rd_in_search, clock, reset, cmd.rd_en,
                    (state == S_LIN) || (state == S_BIN_RD))

   // a taken response with nothing new behind it leaves the slot empty
   `KT_ASSERT_NEXT(a_rsp_drain, clock, reset,
                   rsp_valid && !rsp_stall && !cmd.rsp_load, !rsp_valid)

endmodule

`default_nettype wire
